// ===== src/mdc_pkg.sv =====
// Shared types and constants of the maze carver.
package mdc_pkg;

    // Command codes carried in the input tuser
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Direction codes
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Bit positions inside one cell entry
    localparam int BIT_UP    = 0;
    localparam int BIT_RIGHT = 1;
    localparam int BIT_DOWN  = 2;
    localparam int BIT_LEFT  = 3;
    localparam int BIT_VIS   = 4;

    localparam int GRID_SIDE_W   = 6;
    localparam int GRID_SIDE_RST = 10;
    localparam int IDX_W         = 10;

    typedef logic [4:0] t_cell_bits;

    typedef enum logic [3:0] {
        S_CLR,
        S_START,
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_NBCHK,
        S_CURRD,
        S_CURWR,
        S_STUCK,
        S_POPW,
        S_RDOUT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_req;

    typedef struct packed {
        logic init;
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

// ===== src/maze_dfs_carver_core.sv =====
// Top level of the depth-first maze carver: control sequencer and ports.
//
//  channel   dir  beat content
//  -------   ---  --------------------------------------------------------
//  s (in)    in   tuser: cmd; tdata: rand_dir, read_index
//  m (out)   out  tdata: cell_res, open_up/right/down/left, moved, next_cell,
//                 done_res
//  cfg       in   grid_side, written whenever i_cfg_wen is high
//
// After reset the cell memory is swept to zero, one entry a cycle; no beat is
// taken meanwhile. A start command sweeps again, then seeds cell 0. A step
// runs a column divide, then tests the directions in turn: one ruled out at
// the border is skipped, and a neighbor is read on the single cell memory
// port; then comes a pop or a write-back, and the read-out. Once the maze
// is finished a step goes straight to the read-out.
// One item is in work at a time; a new beat is taken while the previous
// result still waits in the output register, and the sequencer holds at its
// last state until that register frees up.
module maze_dfs_carver_core #(
    parameter int MAX_SIDE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_wen,
    input  logic [5:0]  i_cfg_wdata,    // grid_side
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,      // [1:0] rand_dir, [11:2] read_index, rest zero
    input  logic [1:0]  i_s_tuser,      // [1:0] cmd
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata       // [9:0] cell_res, [10] open_up, [11] open_right,
                                        // [12] open_down, [13] open_left, [14] moved,
                                        // [24:15] next_cell, [25] done_res, rest zero
);
    import mdc_pkg::*;

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int CW    = $clog2(CELLS);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int AW    = 2 * SW;
    localparam int EW    = AW + 1;
    localparam int GW    = (SW > GRID_SIDE_W) ? SW : GRID_SIDE_W;

    // ---------------------------------------------------------------
    // Configuration and effective side
    // ---------------------------------------------------------------
    logic [GRID_SIDE_W-1:0] r_grid;
    logic [SW-1:0]          r_side;
    logic [SW-1:0]          n_side;
    logic [AW-1:0]          r_area;
    logic [GW-1:0]          grid_e;

    assign grid_e = GW'(r_grid);

    // clamp side into 2..MAX_SIDE
    always_comb begin
        if (grid_e < GW'(2)) begin
            n_side = SW'(2);
        end else if (grid_e > GW'(MAX_SIDE)) begin
            n_side = SW'(MAX_SIDE);
        end else begin
            n_side = SW'(grid_e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GRID_SIDE_W'(GRID_SIDE_RST);
        end else if (i_cfg_wen) begin
            r_grid <= i_cfg_wdata;
        end
    end

    // register the clamp, then the square, so each is one step deep
    always_ff @(posedge i_clk) begin
        r_side <= n_side;
        r_area <= AW'(r_side) * AW'(r_side);
    end

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state                 r_state;
    t_state                 n_state;
    logic [CW-1:0]          r_clr;
    logic                   r_start_pass;
    logic [CW-1:0]          r_cur;
    logic                   r_fin;
    logic [CW-1:0]          r_c;
    logic [CW-1:0]          r_nb;
    logic [1:0]             r_cmd;
    logic [1:0]             r_dir;
    logic [IDX_W-1:0]       r_ridx;
    logic [1:0]             r_k;
    logic                   r_moved;
    logic                   r_zero;
    t_cell_bits             r_here;
    t_cell_bits             r_there;
    logic                   r_out_valid;
    logic [31:0]            r_out_data;

    logic                   s_accept;
    logic                   out_free;
    logic                   clr_last;

    // memory and unit hookups
    t_mem_req               mem_req;
    logic [CW-1:0]          mem_addr;
    t_cell_bits             mem_wdata;
    t_cell_bits             mem_rdata;
    t_stk_ctl               stk_ctl;
    logic [CW-1:0]          stk_pop_data;
    logic                   stk_empty;
    logic                   div_start;
    logic                   div_done;
    logic [SW-1:0]          col;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign clr_last   = (r_clr == CW'(CELLS - 1));

    // ---------------------------------------------------------------
    // Neighbor probe for the direction under test
    // ---------------------------------------------------------------
    logic [1:0]    probe_dir;
    logic [EW-1:0] c_e;
    logic [EW-1:0] s_e;
    logic [EW-1:0] a_e;
    logic [EW-1:0] nb_e;
    logic          probe_ok;
    logic          in_grid;
    t_cell_bits    here_m;
    t_cell_bits    there_m;
    logic          last_dir;
    logic          nb_vis;

    assign probe_dir = r_dir + r_k;
    assign c_e       = EW'(r_c);
    assign s_e       = EW'(r_side);
    assign a_e       = EW'(r_area);
    assign in_grid   = (c_e < a_e);
    assign last_dir  = (r_k == 2'd3);
    assign nb_vis    = mem_rdata[BIT_VIS];

    always_comb begin
        here_m  = '0;
        there_m = '0;
        case (probe_dir)
            DIR_UP: begin
                probe_ok          = (c_e >= s_e);
                nb_e              = c_e - s_e;
                here_m[BIT_UP]    = 1'b1;
                there_m[BIT_DOWN] = 1'b1;
            end
            DIR_DOWN: begin
                probe_ok          = ((c_e + s_e) < a_e);
                nb_e              = c_e + s_e;
                here_m[BIT_DOWN]  = 1'b1;
                there_m[BIT_UP]   = 1'b1;
            end
            DIR_LEFT: begin
                probe_ok           = (col != '0);
                nb_e               = c_e - 1'b1;
                here_m[BIT_LEFT]   = 1'b1;
                there_m[BIT_RIGHT] = 1'b1;
            end
            default: begin
                probe_ok           = (col != (r_side - 1'b1));
                nb_e               = c_e + 1'b1;
                here_m[BIT_RIGHT]  = 1'b1;
                there_m[BIT_LEFT]  = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (clr_last) begin
                    n_state = r_start_pass ? S_START : S_IDLE;
                end
            end
            S_START: n_state = S_EMIT;
            S_IDLE: begin
                if (s_accept) begin
                    case (i_s_tuser)
                        CMD_START: n_state = S_CLR;
                        CMD_STEP:  n_state = r_fin ? S_RDOUT : S_DIV;
                        CMD_READ:  n_state = S_RDOUT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!in_grid) begin
                    n_state = S_STUCK;
                end else if (probe_ok) begin
                    n_state = S_NBCHK;
                end else if (last_dir) begin
                    n_state = S_STUCK;
                end
            end
            S_NBCHK: begin
                if (!nb_vis) begin
                    n_state = S_CURRD;
                end else begin
                    n_state = last_dir ? S_STUCK : S_PROBE;
                end
            end
            S_CURRD: n_state = S_CURWR;
            S_CURWR: n_state = S_RDOUT;
            S_STUCK: n_state = stk_empty ? S_RDOUT : S_POPW;
            S_POPW:  n_state = S_RDOUT;
            S_RDOUT: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: strobes to the memories and the divider
    // ---------------------------------------------------------------
    always_comb begin
        mem_req       = '0;
        mem_addr      = r_c;
        mem_wdata     = '0;
        stk_ctl       = '0;
        div_start     = 1'b0;
        case (r_state)
            S_CLR: begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
                mem_addr   = r_clr;
            end
            S_START: begin
                // seed cell 0 as visited and push it
                mem_req.en         = 1'b1;
                mem_req.we         = 1'b1;
                mem_addr           = '0;
                mem_wdata[BIT_VIS] = 1'b1;
                stk_ctl.init       = 1'b1;
            end
            S_IDLE: begin
                div_start = s_accept && (i_s_tuser == CMD_STEP) && !r_fin;
            end
            S_PROBE: begin
                mem_req.en = in_grid && probe_ok;
                mem_addr   = CW'(nb_e);
            end
            S_NBCHK: begin
                // open the far wall and mark the neighbor visited
                mem_req.en = !nb_vis;
                mem_req.we = 1'b1;
                mem_addr   = r_nb;
                mem_wdata  = mem_rdata | r_there;
                mem_wdata[BIT_VIS] = 1'b1;
            end
            S_CURRD: begin
                mem_req.en = 1'b1;
            end
            S_CURWR: begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_wdata    = mem_rdata | r_here;
                stk_ctl.push = 1'b1;
            end
            S_STUCK: begin
                stk_ctl.pop = !stk_empty;
            end
            S_RDOUT: begin
                mem_req.en = !r_zero;
                mem_addr   = (r_cmd == CMD_READ) ? CW'(r_ridx) : r_c;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control and datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_start_pass <= 1'b0;
            r_cur        <= '0;
            r_fin        <= 1'b0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // load a fresh result, else drop the one just taken
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_START: begin
                    r_cur <= '0;
                    r_fin <= 1'b0;
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_k   <= '0;
                        r_clr <= '0;
                        r_start_pass <= (i_s_tuser == CMD_START);
                    end
                end
                S_PROBE: begin
                    if (in_grid && !probe_ok && !last_dir) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_NBCHK: begin
                    if (nb_vis && !last_dir) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_CURWR: begin
                    r_cur <= r_nb;
                end
                S_STUCK: begin
                    if (stk_empty) begin
                        r_fin <= 1'b1;
                    end
                end
                S_POPW: begin
                    r_cur <= stk_pop_data;
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // payload registers: no reset needed
    logic [IDX_W-1:0] cell_res;
    t_cell_bits       out_bits;

    assign cell_res = (r_cmd == CMD_READ) ? r_ridx : IDX_W'(r_c);
    assign out_bits = r_zero ? '0 : mem_rdata;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    r_cmd   <= i_s_tuser;
                    r_dir   <= i_s_tdata[1:0];
                    r_ridx  <= i_s_tdata[11:2];
                    r_c     <= r_cur;
                    r_moved <= 1'b0;
                    // out-of-range reads return no openings
                    r_zero  <= (i_s_tuser == CMD_READ) &&
                               (32'(i_s_tdata[11:2]) >= CELLS);
                end
            end
            S_START: begin
                r_c    <= '0;
                r_zero <= 1'b1;
            end
            S_PROBE: begin
                r_nb    <= CW'(nb_e);
                r_here  <= here_m;
                r_there <= there_m;
            end
            S_CURWR: begin
                r_moved <= 1'b1;
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out_data <= {6'b0, r_fin, IDX_W'(r_cur), r_moved,
                                   out_bits[BIT_LEFT], out_bits[BIT_DOWN],
                                   out_bits[BIT_RIGHT], out_bits[BIT_UP], cell_res};
                end
            end
            default: begin
                r_c <= r_c;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---------------------------------------------------------------
    // Units
    // ---------------------------------------------------------------
    mdc_cell_mem #(
        .CELLS (CELLS),
        .CW    (CW)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    mdc_stack #(
        .CELLS (CELLS),
        .CW    (CW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stk_ctl),
        .i_push_data (r_c),
        .o_pop_data  (stk_pop_data),
        .o_empty     (stk_empty)
    );

    // column of the current cell: cell index modulo the side as it stands now
    mdc_divmod #(
        .CW (CW),
        .SW (SW)
    ) u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cur),
        .i_divisor  (n_side),
        .o_done     (div_done),
        .o_rem      (col)
    );

endmodule

// ===== src/mdc_cell_mem.sv =====
// Cell memory: one read/write port, registered read data.
module mdc_cell_mem #(
    parameter int CELLS = 1024,
    parameter int CW    = 10
) (
    input  logic                i_clk,
    input  mdc_pkg::t_mem_req   i_req,
    input  logic [CW-1:0]       i_addr,
    input  mdc_pkg::t_cell_bits i_wdata,
    output mdc_pkg::t_cell_bits o_rdata
);
    import mdc_pkg::*;

    t_cell_bits r_mem [CELLS];
    t_cell_bits r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mdc_stack.sv =====
// Backtrack stack: memory plus depth pointer, registered pop data.
module mdc_stack #(
    parameter int CELLS = 1024,
    parameter int CW    = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdc_pkg::t_stk_ctl i_ctl,
    input  logic [CW-1:0]     i_push_data,
    output logic [CW-1:0]     o_pop_data,
    output logic              o_empty
);
    import mdc_pkg::*;

    logic [CW-1:0] r_mem [CELLS];
    logic [CW-1:0] r_rdata;
    logic [CW:0]   r_depth;
    logic [CW:0]   n_depth;
    logic          full;
    logic [CW:0]   depth_m1;

    assign full     = (r_depth == (CW+1)'(CELLS));
    assign depth_m1 = r_depth - 1'b1;
    assign o_empty  = (r_depth == '0);

    always_comb begin
        n_depth = r_depth;
        if (i_ctl.init) begin
            n_depth = (CW+1)'(1);
        end else if (i_ctl.push && !full) begin
            n_depth = r_depth + 1'b1;
        end else if (i_ctl.pop && !o_empty) begin
            n_depth = depth_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    // init seeds entry 0 with cell 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_mem[0] <= '0;
        end else if (i_ctl.push && !full) begin
            r_mem[r_depth[CW-1:0]] <= i_push_data;
        end
        if (i_ctl.pop) begin
            r_rdata <= r_mem[depth_m1[CW-1:0]];
        end
    end

    assign o_pop_data = r_rdata;

endmodule

// ===== src/mdc_divmod.sv =====
// Iterative remainder unit: one dividend bit per cycle.
module mdc_divmod #(
    parameter int CW = 10,
    parameter int SW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [SW-1:0] o_rem
);
    import mdc_pkg::*;

    localparam int NW = $clog2(CW + 1);

    logic [CW-1:0] r_num;
    logic [SW-1:0] r_div;
    logic [SW-1:0] r_rem;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [SW:0]   trial;
    logic [SW:0]   diff;

    assign trial = {r_rem, r_num[CW-1]};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(CW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restore when the trial falls below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= diff[SW] ? trial[SW-1:0] : diff[SW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
